// ----- src/detector_response_accumulate_unit_macros.svh -----
// assertion macros for the detector response accumulate unit
`ifndef DETECTOR_RESPONSE_ACCUMULATE_UNIT_MACROS_SVH
`define DETECTOR_RESPONSE_ACCUMULATE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define DRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dra: implication check failed");

// next-cycle implication
`define DRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dra: next-cycle check failed");

`else

`define DRA_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define DRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/dra_pkg.sv -----
package dra_pkg;

	// field widths
	localparam int KIND_W    = 2;
	localparam int IDX_W     = 10;
	localparam int VAL_W     = 16;
	localparam int ANG_W     = 10;
	localparam int BIN_W     = 6;
	localparam int RESP_W    = 42;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	// internal arithmetic widths
	localparam int POS_W      = 36;  // signed Q24.12 sample positions
	localparam int Q_W        = 60;  // signed distance times index scale
	localparam int FRAC_SHIFT = 28;  // fraction bits of that product
	localparam int PROD_W     = 32;  // profile point times beam weight

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// item kinds
	localparam kind_t KIND_WEIGHT  = 2'd0;
	localparam kind_t KIND_PROFILE = 2'd1;
	localparam kind_t KIND_COMPUTE = 2'd2;

	// register indexes
	localparam cfg_idx_t CFG_BEAM_START  = 3'd0;
	localparam cfg_idx_t CFG_BEAM_STEP   = 3'd1;
	localparam cfg_idx_t CFG_BIN_SPACING = 3'd2;
	localparam cfg_idx_t CFG_VOXEL_WIDTH = 3'd3;
	localparam cfg_idx_t CFG_INDEX_SCALE = 3'd4;

endpackage

// ----- src/dra_in_if.sv -----
interface dra_in_if
	import dra_pkg::*;
();
	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [IDX_W-1:0]  sample_index;
	logic [VAL_W-1:0]  sample_value;
	logic [ANG_W-1:0]  angle;

	modport source (output valid, kind, sample_index, sample_value, angle, input ready);
	modport sink (input valid, kind, sample_index, sample_value, angle, output ready);
endinterface

// ----- src/dra_out_if.sv -----
interface dra_out_if
	import dra_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ANG_W-1:0]  angle_out;
	logic [BIN_W-1:0]  bin;
	logic [RESP_W-1:0] response;
	logic              last;

	modport source (output valid, angle_out, bin, response, last, input ready);
	modport sink (input valid, angle_out, bin, response, last, output ready);
endinterface

// ----- src/detector_response_accumulate_unit.sv -----
// Load items are accepted one per cycle while no compute item is running; a compute item holds the
// input through accept, setup and run, with one sample per cycle set by the single read port of each
// table unless output backpressure holds the last sample of a bin until the result register is free;
// a bin's result passes through the table read and product registers into the result register. Reset
// (arst_n low, asynchronous) clears control, counters, valids, accumulator and configuration registers
// to zero; the weight and profile tables are undefined until written.
`include "detector_response_accumulate_unit_macros.svh"

module detector_response_accumulate_unit
	import dra_pkg::*;
#(
	parameter int BEAM_SAMPLES   = 512,
	parameter int PROFILE_POINTS = 1024,
	parameter int RESPONSE_BINS  = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	dra_in_if.sink           in_ch,
	dra_out_if.source        out_ch,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int SW = $clog2(BEAM_SAMPLES);
	localparam int PW = $clog2(PROFILE_POINTS);
	localparam int HI_W = Q_W - FRAC_SHIFT;
	localparam logic [SW-1:0] LAST_SAMPLE = SW'(BEAM_SAMPLES - 1);
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(RESPONSE_BINS - 1);
	localparam logic [PW-1:0] LAST_POINT = PW'(PROFILE_POINTS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN} state_t;

	state_t state_q;

	// configuration registers
	logic signed [23:0] start_q;
	logic [22:0]        step_q;
	logic signed [23:0] spacing_q;
	logic [22:0]        width_q;
	logic [23:0]        scale_q;

	// run counters
	logic [SW-1:0]    sample_cnt_q;
	logic [BIN_W-1:0] bin_cnt_q;
	logic [ANG_W-1:0] angle_q;

	// running positions and index products
	logic signed [POS_W-1:0] r_q;
	logic signed [POS_W-1:0] rmin_q;
	logic signed [Q_W-1:0]   q_q;
	logic signed [Q_W-1:0]   qb_q;
	logic signed [Q_W-1:0]   step_prod_q;
	logic signed [Q_W-1:0]   spacing_prod_q;

	// tables
	logic [VAL_W-1:0] weight_mem [BEAM_SAMPLES];
	logic [VAL_W-1:0] profile_mem [PROFILE_POINTS];

	// pipeline
	logic               valid_s1_q;
	logic               last_s1;
	logic               skip_s1;
	logic [BIN_W-1:0]   bin_s1;
	logic               last_bin_s1;
	logic [ANG_W-1:0]   angle_s1;
	logic [VAL_W-1:0]   weight_s1;
	logic [VAL_W-1:0]   profile_s1;

	logic               valid_s2_q;
	logic               last_s2;
	logic [BIN_W-1:0]   bin_s2;
	logic               last_bin_s2;
	logic [ANG_W-1:0]   angle_s2;
	logic [PROD_W-1:0]  prod_s2;

	logic [RESP_W-1:0]  acc_q;
	logic               out_valid_q;
	logic [ANG_W-1:0]   out_angle_q;
	logic [BIN_W-1:0]   out_bin_q;
	logic [RESP_W-1:0]  out_resp_q;
	logic               out_last_q;

	// combinational
	logic                    in_acc;
	logic                    last_sample;
	logic                    last_bin;
	logic                    out_busy;
	logic                    issue;
	logic                    skip;
	logic [HI_W-1:0]         idx_hi;
	logic [PW-1:0]           prof_addr;
	logic signed [24:0]      sw_sum;
	logic signed [24:0]      scale_s;
	logic signed [49:0]      a_prod;
	logic signed [48:0]      b_prod;
	logic [46:0]             c_prod;
	logic signed [Q_W-1:0]   qb_next;
	logic [RESP_W:0]         acc_sum;
	logic [RESP_W-1:0]       acc_sat;
	logic signed [POS_W-1:0] start_ext;
	logic signed [POS_W-1:0] step_ext;
	logic signed [POS_W-1:0] spacing_ext;
	logic signed [POS_W-1:0] width_ext;

	// handshakes and sequencing
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && (state_q == ST_IDLE);
	assign last_sample = (sample_cnt_q == LAST_SAMPLE);
	assign last_bin    = (bin_cnt_q == LAST_BIN);
	assign out_busy    = out_valid_q || (valid_s1_q && last_s1) || (valid_s2_q && last_s2);
	assign issue       = (state_q == ST_RUN) && !(last_sample && out_busy);

	// sign and zero extension of registers
	assign start_ext   = {{(POS_W-24){start_q[23]}}, start_q};
	assign step_ext    = {{(POS_W-23){1'b0}}, step_q};
	assign spacing_ext = {{(POS_W-24){spacing_q[23]}}, spacing_q};
	assign width_ext   = {{(POS_W-23){1'b0}}, width_q};

	// products set up once per compute
	always_comb begin
		sw_sum  = 25'(start_q) + signed'({2'b00, width_q});
		scale_s = signed'({1'b0, scale_q});
		a_prod  = 50'(sw_sum) * 50'(scale_s);
		b_prod  = 49'(spacing_q) * 49'(scale_s);
		c_prod  = 47'(step_q) * 47'(scale_q);
	end

	assign qb_next = qb_q - spacing_prod_q;

	// skip test and profile index with clamp
	assign skip   = (r_q < rmin_q);
	assign idx_hi = q_q[Q_W-1:FRAC_SHIFT];
	assign prof_addr = (idx_hi >= HI_W'(PROFILE_POINTS)) ? LAST_POINT : idx_hi[PW-1:0];

	// saturating accumulate
	assign acc_sum = {1'b0, acc_q} + (RESP_W+1)'(prod_s2);
	assign acc_sat = acc_sum[RESP_W] ? {RESP_W{1'b1}} : acc_sum[RESP_W-1:0];

	// beam weight table
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.kind == KIND_WEIGHT &&
				{1'b0, in_ch.sample_index} < (IDX_W+1)'(BEAM_SAMPLES)) begin
			weight_mem[in_ch.sample_index[SW-1:0]] <= in_ch.sample_value;
		end
		weight_s1 <= weight_mem[sample_cnt_q];
	end

	// voxel profile table
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.kind == KIND_PROFILE &&
				{1'b0, in_ch.sample_index} < (IDX_W+1)'(PROFILE_POINTS)) begin
			profile_mem[in_ch.sample_index[PW-1:0]] <= in_ch.sample_value;
		end
		profile_s1 <= profile_mem[prof_addr];
	end

	// control state, configuration, counters, valids, accumulator and result register flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_q      <= '0;
			step_q       <= '0;
			spacing_q    <= '0;
			width_q      <= '0;
			scale_q      <= '0;
			sample_cnt_q <= '0;
			bin_cnt_q    <= '0;
			angle_q      <= '0;
			valid_s1_q   <= 1'b0;
			valid_s2_q   <= 1'b0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BEAM_START:  start_q   <= cfg_data;
					CFG_BEAM_STEP:   step_q    <= cfg_data[22:0];
					CFG_BIN_SPACING: spacing_q <= cfg_data;
					CFG_VOXEL_WIDTH: width_q   <= cfg_data[22:0];
					CFG_INDEX_SCALE: scale_q   <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.kind == KIND_COMPUTE) begin
						state_q      <= ST_SETUP;
						angle_q      <= in_ch.angle;
						sample_cnt_q <= '0;
						bin_cnt_q    <= '0;
					end
				end
				ST_SETUP: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (issue) begin
						if (last_sample) begin
							sample_cnt_q <= '0;
							if (last_bin) begin
								bin_cnt_q <= '0;
								state_q   <= ST_IDLE;
							end else begin
								bin_cnt_q <= bin_cnt_q + 1'b1;
							end
						end else begin
							sample_cnt_q <= sample_cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			valid_s1_q <= issue;
			valid_s2_q <= valid_s1_q;

			// accumulate, close a bin into the result register
			if (valid_s2_q) begin
				if (last_s2) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_sat;
				end
			end

			if (valid_s2_q && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: positions, index products, pipeline payload
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			r_q            <= start_ext;
			rmin_q         <= -width_ext;
			q_q            <= Q_W'(a_prod);
			qb_q           <= Q_W'(a_prod);
			step_prod_q    <= signed'(Q_W'(c_prod));
			spacing_prod_q <= Q_W'(b_prod);
		end else if (issue) begin
			if (last_sample) begin
				r_q    <= start_ext;
				rmin_q <= rmin_q + spacing_ext;
				qb_q   <= qb_next;
				q_q    <= qb_next;
			end else begin
				r_q <= r_q + step_ext;
				q_q <= q_q + step_prod_q;
			end
		end

		last_s1     <= last_sample;
		skip_s1     <= skip;
		bin_s1      <= bin_cnt_q;
		last_bin_s1 <= last_bin;
		angle_s1    <= angle_q;

		last_s2     <= last_s1;
		bin_s2      <= bin_s1;
		last_bin_s2 <= last_bin_s1;
		angle_s2    <= angle_s1;
		prod_s2     <= skip_s1 ? '0 : PROD_W'(profile_s1) * PROD_W'(weight_s1);

		if (valid_s2_q && last_s2) begin
			out_angle_q <= angle_s2;
			out_bin_q   <= bin_s2;
			out_resp_q  <= acc_sat;
			out_last_q  <= last_bin_s2;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.angle_out = out_angle_q;
	assign out_ch.bin       = out_bin_q;
	assign out_ch.response  = out_resp_q;
	assign out_ch.last      = out_last_q;

	// a closing bin never lands on an unread result
	`DRA_ASSERT_IMPL(a_no_overwrite, clk, arst_n, valid_s2_q && last_s2, !out_valid_q)
	// last sample of last bin returns the sequencer to idle
	`DRA_ASSERT_NEXT(a_done_idle, clk, arst_n, issue && last_sample && last_bin, state_q == ST_IDLE)
	// table reads only enter the pipeline from the run state
	`DRA_ASSERT_IMPL(a_s1_from_run, clk, arst_n, valid_s1_q, $past(state_q) == ST_RUN)

endmodule
